@@ hw/rtl/oaht_pkg.sv @@
// shared types and constants for the open addressing hash table
package oaht_pkg;

    localparam int TABLE_SLOTS_DEF = 256;
    localparam int KEY_W           = 32;
    localparam int HASH_W          = 32;
    localparam int VAL_W           = 64;
    localparam int LIMIT_W         = 8;
    localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 8'd192;

    typedef enum logic [1:0] {
        REQ_GET = 2'd0,
        REQ_SET = 2'd1,
        REQ_DEL = 2'd2,
        REQ_CLR = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,
        KIND_LIVE  = 2'd1,
        KIND_TOMB  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
    } t_slot;

endpackage

@@ hw/rtl/oaht_slot_ram.sv @@
// slot memory: one write port, one read port, registered read data
module oaht_slot_ram #(
    parameter int DEPTH = oaht_pkg::TABLE_SLOTS_DEF,
    parameter int WIDTH = $bits(oaht_pkg::t_slot)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/oaht_hash_mod.sv @@
// reduces a key hash to a home slot index (mask or reciprocal multiply)
module oaht_hash_mod #(
    parameter int TABLE_SLOTS = oaht_pkg::TABLE_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [oaht_pkg::HASH_W-1:0]    i_hash,
    output logic                           o_done,
    output logic [$clog2(TABLE_SLOTS)-1:0] o_slot
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int HW    = oaht_pkg::HASH_W;

    generate
        if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0) begin : g_pow2
            logic             r_done;
            logic [IDX_W-1:0] r_slot;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_slot <= i_hash[IDX_W-1:0];
                end
            end

            assign o_done = r_done;
            assign o_slot = r_slot;
        end else begin : g_recip
            // rounded-up reciprocal, exact quotient for every 32-bit hash
            localparam logic [63:0] MAGIC_FULL =
                ((64'd1 << (HW + IDX_W)) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
            localparam logic [HW:0]   MAGIC   = (HW+1)'(MAGIC_FULL);
            localparam logic [HW-1:0] DIVISOR = HW'(TABLE_SLOTS);

            logic             r_step1;
            logic             r_step2;
            logic             r_done;
            logic [HW-1:0]    r_hash;
            logic [HW-1:0]    r_quot;
            logic [IDX_W-1:0] r_rem;
            logic [2*HW:0]    w_prod;
            logic [HW-1:0]    w_left;

            always_comb begin
                w_prod = {{(HW+1){1'b0}}, r_hash} * {{HW{1'b0}}, MAGIC};
                w_left = r_hash - (r_quot * DIVISOR);
            end

            // quotient registered first, remainder in the next cycle
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_step1 <= 1'b0;
                    r_step2 <= 1'b0;
                    r_done  <= 1'b0;
                end else begin
                    r_step1 <= i_start;
                    r_step2 <= r_step1;
                    r_done  <= r_step2;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_hash <= i_hash;
                end
                if (r_step1) begin
                    r_quot <= HW'(w_prod >> (HW + IDX_W));
                end
                if (r_step2) begin
                    r_rem <= IDX_W'(w_left);
                end
            end

            assign o_done = r_done;
            assign o_slot = r_rem;
        end
    endgenerate

endmodule

@@ hw/rtl/open_addressing_hash_table.sv @@
// top level: linear probing key/value table with tombstones
//
// Input channel (i_in_valid / o_in_stall) carries one request: req_type
// (get, set, delete, clear), key_id, key_hash and value_in. Output channel
// (o_out_valid / i_out_stall) returns exactly one result per request: hit,
// value_out and status. A transfer happens on a clock edge with valid high
// and stall low. Requests are handled one at a time; the output register
// lets the next request start while the previous result waits.
// Get, set and delete probe up to TABLE_SLOTS slots, one slot read per
// cycle from the slot memory, after the home slot is found. The home slot
// comes from a mask when TABLE_SLOTS is a power of two; otherwise from a
// reciprocal multiply with registered quotient and remainder steps.
// Clear sweeps the slot memory, one slot a cycle.
// A new request is taken only once the previous one has reached the
// output register. After reset the same sweep runs with o_in_stall high.
// load_limit is written through i_cfg_we / i_cfg_data (reset 192).
// If the receiver stalls, the finished request is held and no further
// request is taken until the result can move to the output register.
module open_addressing_hash_table #(
    parameter int TABLE_SLOTS = oaht_pkg::TABLE_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_req_type,
    input  logic [oaht_pkg::KEY_W-1:0]      i_key_id,
    input  logic [oaht_pkg::HASH_W-1:0]     i_key_hash,
    input  logic [oaht_pkg::VAL_W-1:0]      i_value_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_hit,
    output logic [oaht_pkg::VAL_W-1:0]      o_value_out,
    output logic                            o_status,
    input  logic                            i_cfg_we,
    input  logic [oaht_pkg::LIMIT_W-1:0]    i_cfg_data
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int CMP_W = (CNT_W > oaht_pkg::LIMIT_W) ? CNT_W + 1 : oaht_pkg::LIMIT_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    oaht_pkg::t_state r_state, n_state;
    logic             r_clr_pend, n_clr_pend;
    logic [CNT_W-1:0] r_count, n_count;
    logic [oaht_pkg::LIMIT_W-1:0] r_limit;
    logic [IDX_W-1:0] r_sweep, n_sweep;
    logic             r_out_valid, n_out_valid;

    oaht_pkg::t_req              r_req;
    logic [oaht_pkg::KEY_W-1:0]  r_key;
    logic [oaht_pkg::VAL_W-1:0]  r_val;
    logic [IDX_W-1:0]            r_cur, n_cur;
    logic [IDX_W-1:0]            r_cnt, n_cnt;
    logic [IDX_W-1:0]            r_tomb, n_tomb;
    logic                        r_tomb_seen, n_tomb_seen;
    logic                        r_found, n_found;
    logic                        r_have, n_have;
    logic [IDX_W-1:0]            r_where, n_where;
    logic                        r_where_tomb, n_where_tomb;
    logic [oaht_pkg::VAL_W-1:0]  r_get_val, n_get_val;
    logic                        r_hit, n_hit;
    logic [oaht_pkg::VAL_W-1:0]  r_vout, n_vout;
    logic                        r_status, n_status;
    logic                        w_load_out;

    logic                  w_accept;
    logic                  w_mod_start;
    logic                  w_mod_done;
    logic [IDX_W-1:0]      w_home;
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    oaht_pkg::t_slot       w_wslot;
    logic [IDX_W-1:0]      w_raddr;
    logic [$bits(oaht_pkg::t_slot)-1:0] w_rdata;
    oaht_pkg::t_slot       w_rslot;

    logic             w_live, w_is_tomb, w_match, w_empty;
    logic             w_tomb_seen_now;
    logic [IDX_W-1:0] w_tomb_now;
    logic [IDX_W-1:0] w_next_idx;
    logic             w_over;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_mod_start = w_accept && (oaht_pkg::t_req'(i_req_type) != oaht_pkg::REQ_CLR);
    assign w_rslot     = oaht_pkg::t_slot'(w_rdata);

    oaht_hash_mod #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_hash_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_hash  (i_key_hash),
        .o_done  (w_mod_done),
        .o_slot  (w_home)
    );

    oaht_slot_ram #(
        .DEPTH (TABLE_SLOTS),
        .WIDTH ($bits(oaht_pkg::t_slot))
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wslot),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // slot classification for the slot read last cycle
    always_comb begin
        w_live          = (w_rslot.kind == oaht_pkg::KIND_LIVE);
        w_is_tomb       = (w_rslot.kind == oaht_pkg::KIND_TOMB);
        w_empty         = !w_live && !w_is_tomb;
        w_match         = w_live && (w_rslot.key == r_key);
        w_tomb_seen_now = r_tomb_seen || w_is_tomb;
        w_tomb_now      = r_tomb_seen ? r_tomb : r_cur;
        w_next_idx      = (r_cur == LAST_IDX) ? '0 : r_cur + 1'b1;
        w_over          = (CMP_W'(r_count) + 1'b1) > CMP_W'(r_limit);
    end

    always_comb begin
        n_state      = r_state;
        n_clr_pend   = r_clr_pend;
        n_count      = r_count;
        n_sweep      = r_sweep;
        n_out_valid  = r_out_valid;
        n_cur        = r_cur;
        n_cnt        = r_cnt;
        n_tomb       = r_tomb;
        n_tomb_seen  = r_tomb_seen;
        n_found      = r_found;
        n_have       = r_have;
        n_where      = r_where;
        n_where_tomb = r_where_tomb;
        n_get_val    = r_get_val;
        n_hit        = r_hit;
        n_vout       = r_vout;
        n_status     = r_status;
        w_load_out   = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_where;
        w_wslot      = '{kind: oaht_pkg::KIND_LIVE, key: r_key, value: r_val};
        w_raddr      = w_next_idx;
        o_in_stall   = (r_state != oaht_pkg::ST_IDLE);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            oaht_pkg::ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_sweep;
                w_wslot = '{kind: oaht_pkg::KIND_EMPTY, key: '0, value: '0};
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == LAST_IDX) begin
                    n_sweep = '0;
                    n_state = r_clr_pend ? oaht_pkg::ST_FINISH : oaht_pkg::ST_IDLE;
                end
            end
            oaht_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (oaht_pkg::t_req'(i_req_type) == oaht_pkg::REQ_CLR) begin
                        n_clr_pend = 1'b1;
                        n_state    = oaht_pkg::ST_CLEAR;
                    end else begin
                        n_state = oaht_pkg::ST_HASH;
                    end
                end
            end
            oaht_pkg::ST_HASH: begin
                w_raddr = w_home;
                if (w_mod_done) begin
                    n_cur       = w_home;
                    n_cnt       = '0;
                    n_tomb_seen = 1'b0;
                    n_state     = oaht_pkg::ST_PROBE;
                end
            end
            oaht_pkg::ST_PROBE: begin
                // next slot is read speculatively every cycle
                n_cur = w_next_idx;
                n_cnt = r_cnt + 1'b1;
                priority if (w_match) begin
                    n_found   = 1'b1;
                    n_have    = 1'b1;
                    n_where   = r_cur;
                    n_get_val = w_rslot.value;
                    n_state   = oaht_pkg::ST_FINISH;
                end else if (w_empty) begin
                    n_found      = 1'b0;
                    n_have       = 1'b1;
                    n_where      = r_tomb_seen ? r_tomb : r_cur;
                    n_where_tomb = r_tomb_seen;
                    n_state      = oaht_pkg::ST_FINISH;
                end else if (r_cnt == LAST_IDX) begin
                    // whole table walked without an empty slot
                    n_found      = 1'b0;
                    n_have       = w_tomb_seen_now;
                    n_where      = w_tomb_now;
                    n_where_tomb = 1'b1;
                    n_state      = oaht_pkg::ST_FINISH;
                end else begin
                    n_tomb_seen = w_tomb_seen_now;
                    n_tomb      = w_tomb_now;
                end
            end
            oaht_pkg::ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = oaht_pkg::ST_IDLE;
                    n_hit       = 1'b0;
                    n_vout      = '0;
                    n_status    = 1'b0;
                    if (r_clr_pend) begin
                        n_clr_pend = 1'b0;
                        n_count    = '0;
                    end else begin
                        unique case (r_req)
                            oaht_pkg::REQ_GET: begin
                                if (r_found) begin
                                    n_hit  = 1'b1;
                                    n_vout = r_get_val;
                                end
                            end
                            oaht_pkg::REQ_DEL: begin
                                if (r_found) begin
                                    n_hit   = 1'b1;
                                    w_we    = 1'b1;
                                    w_wslot = '{kind: oaht_pkg::KIND_TOMB, key: r_key,
                                                value: r_val};
                                end
                            end
                            oaht_pkg::REQ_SET: begin
                                priority if (r_found) begin
                                    w_we = 1'b1;
                                end else if (!r_have) begin
                                    n_status = 1'b1;
                                end else if (r_where_tomb) begin
                                    w_we  = 1'b1;
                                    n_hit = 1'b1;
                                end else if (w_over) begin
                                    n_status = 1'b1;
                                end else begin
                                    w_we    = 1'b1;
                                    n_hit   = 1'b1;
                                    n_count = r_count + 1'b1;
                                end
                            end
                            default: begin
                                n_hit = 1'b0;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = oaht_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= oaht_pkg::ST_CLEAR;
            r_clr_pend  <= 1'b0;
            r_count     <= '0;
            r_limit     <= oaht_pkg::LOAD_LIMIT_RST;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_pend  <= n_clr_pend;
            r_count     <= n_count;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= oaht_pkg::t_req'(i_req_type);
            r_key <= i_key_id;
            r_val <= i_value_in;
        end
        r_cur        <= n_cur;
        r_cnt        <= n_cnt;
        r_tomb       <= n_tomb;
        r_tomb_seen  <= n_tomb_seen;
        r_found      <= n_found;
        r_have       <= n_have;
        r_where      <= n_where;
        r_where_tomb <= n_where_tomb;
        r_get_val    <= n_get_val;
        if (w_load_out) begin
            r_hit    <= n_hit;
            r_vout   <= n_vout;
            r_status <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_value_out = r_vout;
    assign o_status    = r_status;

endmodule

@@ hw/rtl/oaht_checker.sv @@
// port-level checks for the hash table, bound to the top level
module oaht_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic                         o_hit,
    input logic [oaht_pkg::VAL_W-1:0]   o_value_out,
    input logic                         o_status
);

    // clearing pass holds off requests and no result is pending after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_stall && !o_out_valid))
        else $error("request taken or result shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_hit)
            && $stable(o_value_out) && $stable(o_status)))
        else $error("stalled result changed");

    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (!o_hit && (o_value_out == '0)))
        else $error("refused set carries hit or value");

    a_value_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_value_out != '0)) |-> o_hit)
        else $error("nonzero value without hit");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_hit       (o_hit),
    .o_value_out (o_value_out),
    .o_status    (o_status)
);
